[hdl/rmvn_pkg.sv]
// shared types and constants for the running mean and variance normalizer
`default_nettype none
package rmvn_pkg;

	localparam logic [1:0] CMD_OBSERVE   = 2'd0;
	localparam logic [1:0] CMD_NORMALIZE = 2'd1;
	localparam logic [1:0] CMD_QUERY     = 2'd2;
	localparam logic [1:0] CMD_RESERVED  = 2'd3;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [5:0]         channel;
		logic signed [31:0] sample;
		logic               last;
	} req_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic               passed_through;
		logic               last_out;
	} rsp_t;

	typedef struct packed {
		logic        start;
		logic [63:0] dividend;
		logic [32:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quot;
	} div_stat_t;

endpackage
`default_nettype wire

[hdl/rmvn_div.sv]
// restoring divider, one quotient bit per cycle, quotient rounded half up
`default_nettype none
module rmvn_div
	import rmvn_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire div_req_t  dreq,
	output div_stat_t      dstat
);

	logic        busy_q;
	logic        fin_q;
	logic [5:0]  cnt_q;
	logic [32:0] rem_q;
	logic [63:0] quo_q;
	logic [32:0] dvs_q;
	logic        done_q;
	logic [63:0] res_q;

	logic [33:0] rem_sh;
	logic        ge;
	logic [33:0] rem_sub;
	logic        rnd_up;

	always_comb begin
		rem_sh  = {rem_q, quo_q[63]};
		ge      = rem_sh >= {1'b0, dvs_q};
		rem_sub = rem_sh - {1'b0, dvs_q};
		rnd_up  = {rem_q, 1'b0} >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (dreq.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				rem_q  <= '0;
				quo_q  <= dreq.dividend;
				dvs_q  <= dreq.divisor;
			end else if (busy_q) begin
				rem_q  <= ge ? rem_sub[32:0] : rem_sh[32:0];
				quo_q  <= {quo_q[62:0], ge};
				cnt_q  <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
				res_q  <= quo_q + {63'b0, rnd_up};
			end
		end
	end

	assign dstat.done = done_q;
	assign dstat.quot = res_q;

endmodule
`default_nettype wire

[hdl/running_mean_variance_normalizer.sv]
// Per-channel Welford running mean/variance with z-score normalization.
// Mean and squared-deviation sums live in two single-port-write RAMs with a
// registered read; after reset a clearing pass zeroes them while req_stall
// is held. One request is worked at a time. The shared 64-step divider
// serves the mean step, the variance and the quotient, next to a 32-step
// square root and a 32x32 multiplier whose partial products are summed for
// the deviation product. A normalize or query while the count is below two
// is passed through without that arithmetic, and a request with an unused
// command or an out-of-range channel is dropped without a response. A
// result that finds the previous response still stalled waits in the output
// stage for as long as that stall lasts.
`default_nettype none
module running_mean_variance_normalizer
	import rmvn_pkg::*;
#(
	parameter int CHANNELS = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp
);

	localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic signed [50:0] MEAN_MAX = 51'sh7FFF_FFFF_FFFF;
	localparam logic signed [50:0] MEAN_MIN = -51'sh8000_0000_0000;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_RD, ST_DECIDE, ST_OBS_DIV, ST_OBS_D2, ST_MUL,
		ST_OBS_WB, ST_VAR_DIV, ST_SQRT, ST_SQ_FIN, ST_SD_USE, ST_NRM_DIV, ST_OUT
	} state_t;

	state_t             state_q;
	logic [AW-1:0]      clr_q;
	logic [31:0]        count_q;
	logic [AW-1:0]      addr_q;
	logic [1:0]         cmd_q;
	logic signed [47:0] x_q;
	logic               last_q;
	logic [47:0]        mean_rd_q;
	logic [63:0]        m2_rd_q;
	logic [48:0]        mag_q;
	logic               neg_q;
	logic [47:0]        mean_new_q;
	logic [48:0]        d2mag_q;
	logic [2:0]         mcnt_q;
	logic [63:0]        prod_s1;
	logic [1:0]         k_s1;
	logic [99:0]        acc_q;
	logic [63:0]        sq_v_q;
	logic [63:0]        sq_r_q;
	logic [63:0]        sq_bit_q;
	logic [4:0]         sq_cnt_q;
	logic [32:0]        sd_q;
	rsp_t               res_q;
	rsp_t               rsp_q;
	logic               rsp_valid_q;

	logic [47:0] mean_mem [CHANNELS];
	logic [63:0] m2_mem [CHANNELS];

	div_req_t  dreq;
	div_stat_t dstat;

	rmvn_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.dreq  (dreq),
		.dstat (dstat)
	);

	// datapath helpers
	logic signed [49:0] diff;
	logic [49:0]        diff_mag;
	logic signed [50:0] mean_sum;
	logic signed [49:0] diff2;
	logic [49:0]        diff2_mag;
	logic [31:0]        mul_a;
	logic [31:0]        mul_b;
	logic [99:0]        prod_sh;
	logic [99:0]        rnd;
	logic [63:0]        p64;
	logic [64:0]        m2_sum;
	logic [63:0]        m2_new;
	logic [63:0]        sq_try;
	logic               in_ok;
	logic               we;
	logic [AW-1:0]      wa;
	logic [47:0]        mean_wd;
	logic [63:0]        m2_wd;
	logic [31:0]        nvar;
	logic [31:0]        dvar;

	always_comb begin
		diff     = $signed({{2{x_q[47]}}, x_q}) - $signed({{2{mean_rd_q[47]}}, mean_rd_q});
		diff_mag = diff[49] ? 50'(-diff) : 50'(diff);
		mean_sum = $signed({{3{mean_rd_q[47]}}, mean_rd_q})
			+ (neg_q ? -$signed({2'b0, dstat.quot[48:0]}) : $signed({2'b0, dstat.quot[48:0]}));
		diff2     = $signed({{2{x_q[47]}}, x_q})
			- $signed({{2{mean_new_q[47]}}, mean_new_q});
		diff2_mag = diff2[49] ? 50'(-diff2) : 50'(diff2);
		mul_a = mcnt_q[1] ? {15'b0, mag_q[48:32]} : mag_q[31:0];
		mul_b = mcnt_q[0] ? {15'b0, d2mag_q[48:32]} : d2mag_q[31:0];
		case (k_s1)
			2'd0:    prod_sh = {36'b0, prod_s1};
			2'd3:    prod_sh = {prod_s1[35:0], 64'b0};
			default: prod_sh = {4'b0, prod_s1, 32'b0};
		endcase
		rnd    = acc_q + 100'h8000_0000;
		p64    = (|rnd[99:96]) ? '1 : rnd[95:32];
		m2_sum = {1'b0, m2_rd_q} + {1'b0, p64};
		m2_new = m2_sum[64] ? '1 : m2_sum[63:0];
		sq_try = sq_r_q + sq_bit_q;
		in_ok  = (req.cmd != CMD_RESERVED) && (32'(req.channel) < CHANNELS);
		nvar   = (count_q == 32'd0) ? 32'd1 : count_q;
		dvar   = count_q - 32'd1;
	end

	// divider requests
	always_comb begin
		dreq = '0;
		if (state_q == ST_DECIDE) begin
			dreq.start = 1'b1;
			if (cmd_q == CMD_OBSERVE) begin
				dreq.dividend = {15'b0, diff_mag[48:0]};
				dreq.divisor  = {1'b0, nvar};
			end else begin
				dreq.dividend = m2_rd_q;
				dreq.divisor  = {1'b0, dvar};
			end
		end else if (state_q == ST_SD_USE && cmd_q == CMD_NORMALIZE && diff != '0
			&& sd_q != '0) begin
			dreq.start    = 1'b1;
			dreq.dividend = {15'b0, diff_mag[48:0]};
			dreq.divisor  = sd_q;
		end
	end

	always_comb begin
		we      = (state_q == ST_CLEAR) || (state_q == ST_OBS_WB);
		wa      = (state_q == ST_CLEAR) ? clr_q : addr_q;
		mean_wd = (state_q == ST_CLEAR) ? 48'b0 : mean_new_q;
		m2_wd   = (state_q == ST_CLEAR) ? 64'b0 : m2_new;
	end

	always_ff @(posedge clk) begin
		mean_rd_q <= mean_mem[addr_q];
		m2_rd_q   <= m2_mem[addr_q];
		if (we) begin
			mean_mem[wa] <= mean_wd;
			m2_mem[wa]   <= m2_wd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
			mcnt_q      <= '0;
			sq_cnt_q    <= '0;
		end else begin
			if (state_q == ST_OUT && (!rsp_valid_q || !rsp_stall)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(CHANNELS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_valid && in_ok) begin
						addr_q <= AW'(req.channel);
						cmd_q  <= req.cmd;
						x_q    <= {req.sample, 16'b0};
						last_q <= req.last;
						if (req.cmd == CMD_OBSERVE) begin
							if (req.channel == 6'd0 && count_q != '1) begin
								count_q <= count_q + 32'd1;
							end
							state_q <= ST_RD;
						end else if (count_q < 32'd2) begin
							res_q.value <= (req.cmd == CMD_NORMALIZE) ? req.sample
								: 32'sh0001_0000;
							res_q.passed_through <= 1'b1;
							res_q.last_out       <= req.last;
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_RD;
						end
					end
				end
				ST_RD: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					mag_q   <= diff_mag[48:0];
					neg_q   <= diff[49];
					state_q <= (cmd_q == CMD_OBSERVE) ? ST_OBS_DIV : ST_VAR_DIV;
				end
				ST_OBS_DIV: begin
					if (dstat.done) begin
						if (mean_sum > MEAN_MAX) begin
							mean_new_q <= MEAN_MAX[47:0];
						end else if (mean_sum < MEAN_MIN) begin
							mean_new_q <= MEAN_MIN[47:0];
						end else begin
							mean_new_q <= mean_sum[47:0];
						end
						state_q <= ST_OBS_D2;
					end
				end
				ST_OBS_D2: begin
					d2mag_q <= diff2_mag[48:0];
					acc_q   <= '0;
					mcnt_q  <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					// one partial product per cycle, accumulated in the following cycle
					if (mcnt_q != 3'd4) begin
						prod_s1 <= mul_a * mul_b;
						k_s1    <= mcnt_q[1:0];
					end
					if (mcnt_q != 3'd0) begin
						acc_q <= acc_q + prod_sh;
					end
					mcnt_q <= mcnt_q + 3'd1;
					if (mcnt_q == 3'd4) begin
						state_q <= ST_OBS_WB;
					end
				end
				ST_OBS_WB: begin
					state_q <= ST_IDLE;
				end
				ST_VAR_DIV: begin
					if (dstat.done) begin
						sq_v_q   <= dstat.quot;
						sq_r_q   <= '0;
						sq_bit_q <= 64'h4000_0000_0000_0000;
						sq_cnt_q <= '0;
						state_q  <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (sq_v_q >= sq_try) begin
						sq_v_q <= sq_v_q - sq_try;
						sq_r_q <= (sq_r_q >> 1) + sq_bit_q;
					end else begin
						sq_r_q <= sq_r_q >> 1;
					end
					sq_bit_q <= sq_bit_q >> 2;
					sq_cnt_q <= sq_cnt_q + 5'd1;
					if (sq_cnt_q == 5'd31) begin
						state_q <= ST_SQ_FIN;
					end
				end
				ST_SQ_FIN: begin
					sd_q    <= sq_r_q[32:0] + {32'b0, (sq_v_q > sq_r_q)};
					state_q <= ST_SD_USE;
				end
				ST_SD_USE: begin
					res_q.passed_through <= 1'b0;
					res_q.last_out       <= last_q;
					neg_q                <= diff[49];
					if (cmd_q == CMD_QUERY) begin
						res_q.value <= sd_q[32:31] != 2'b0 ? 32'sh7FFF_FFFF : $signed(sd_q[31:0]);
						state_q     <= ST_OUT;
					end else if (diff == '0) begin
						res_q.value <= '0;
						state_q     <= ST_OUT;
					end else if (sd_q == '0) begin
						res_q.value <= diff[49] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
						state_q     <= ST_OUT;
					end else begin
						state_q <= ST_NRM_DIV;
					end
				end
				ST_NRM_DIV: begin
					if (dstat.done) begin
						if (!neg_q) begin
							res_q.value <= (dstat.quot > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF
								: $signed(dstat.quot[31:0]);
						end else begin
							res_q.value <= (dstat.quot >= 64'h8000_0000) ? 32'sh8000_0000
								: $signed(32'(-dstat.quot[31:0]));
						end
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_q   <= res_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// the divider only reports back to a state that waits on it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		dstat.done |-> (state_q == ST_OBS_DIV || state_q == ST_VAR_DIV
			|| state_q == ST_NRM_DIV))
		else $error("divider result with no waiting state");

	a_count_mono: assert property (@(posedge clk) disable iff (!arst_n)
		count_q >= $past(count_q))
		else $error("sample count went down");

	a_clear_block: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |=> (count_q == 32'd0 && !rsp_valid_q))
		else $error("activity during clearing pass");

endmodule
`default_nettype wire
